[src/quadrature_sine_dac_word_generator_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property forms for the word generator checks.
// ----------------------------------------------------------------------------
`ifndef QUADRATURE_SINE_DAC_WORD_GENERATOR_UNIT_ASSERT_SVH
`define QUADRATURE_SINE_DAC_WORD_GENERATOR_UNIT_ASSERT_SVH

// same-cycle implication, off while in reset
`define QSDG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("qsdg: same-cycle check failed");

// next-cycle implication, off while in reset
`define QSDG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("qsdg: next-cycle check failed");

`endif

[src/qsdg_pkg.sv]
// ----------------------------------------------------------------------------
// qsdg_pkg
// Shared types and constants of the quadrature sine DAC word generator.
// ----------------------------------------------------------------------------
package qsdg_pkg;

  localparam int TABLE_DEPTH    = 1024;
  localparam int IDX_W          = $clog2(TABLE_DEPTH);
  localparam int QUARTER        = TABLE_DEPTH / 4;
  localparam int QUEUE_DEPTH    = 2;
  localparam int WORDS_PER_TICK = 4;
  localparam int CNT_W          = $clog2(WORDS_PER_TICK);

  localparam logic [15:0] AMP_RESET = 16'd10813;
  localparam logic [15:0] MID_CODE  = 16'h8000;

  // DAC channel command bytes
  localparam logic [7:0] DAC_CMD_A = 8'h18;
  localparam logic [7:0] DAC_CMD_B = 8'h19;
  localparam logic [7:0] DAC_CMD_C = 8'h1A;
  localparam logic [7:0] DAC_CMD_D = 8'h1B;

  // serial command characters
  localparam logic [7:0] CMD_HV_OFF  = 8'h30;  // '0'
  localparam logic [7:0] CMD_HV_ON   = 8'h31;  // '1'
  localparam logic [7:0] CMD_HV_DAC  = 8'h64;  // 'd'
  localparam logic [7:0] CMD_HV_HIGH = 8'h68;  // 'h'
  localparam logic [7:0] CMD_LASER   = 8'h6C;  // 'l'

  typedef enum logic [1:0] {
    CFG_AMP_X = 2'd0,
    CFG_AMP_Y = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] command_byte;
  } in_t;

  typedef struct packed {
    logic [23:0] dac_word;
    logic        word_valid;
    logic        last;
    logic        hv_enable;
    logic        laser_on;
  } out_t;

  // classified word handed from front to back
  typedef struct packed {
    logic             is_cmd;
    logic [IDX_W-1:0] idx;
    logic             hv;
    logic             laser;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[src/qsdg_front.sv]
// ----------------------------------------------------------------------------
// qsdg_front
// Accepts input words, decodes command bytes, owns flags and phase index.
// ----------------------------------------------------------------------------
module qsdg_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  qsdg_pkg::in_t      in_data,
  output logic               q_push,
  output qsdg_pkg::entry_t   q_entry,
  input  qsdg_pkg::q_stat_t  q_stat
);

  logic                       hv_r, hv_nxt;
  logic                       laser_r, laser_nxt;
  logic [qsdg_pkg::IDX_W-1:0] phase_r, phase_nxt;

  assign in_stall = q_stat.full;
  assign q_push   = in_valid && !q_stat.full;

  always_comb begin
    hv_nxt    = hv_r;
    laser_nxt = laser_r;
    phase_nxt = phase_r;
    if (q_push) begin
      if (in_data.cmd) begin
        unique case (in_data.command_byte) inside
          qsdg_pkg::CMD_HV_ON, qsdg_pkg::CMD_HV_HIGH, qsdg_pkg::CMD_HV_DAC: hv_nxt = 1'b1;
          qsdg_pkg::CMD_HV_OFF: hv_nxt    = 1'b0;
          qsdg_pkg::CMD_LASER:  laser_nxt = !laser_r;
          default:              ;
        endcase
      end else if (phase_r == qsdg_pkg::IDX_W'(qsdg_pkg::TABLE_DEPTH - 1)) begin
        phase_nxt = '0;
      end else begin
        phase_nxt = phase_r + 1'b1;
      end
    end
  end

  // flags travel with the word: post-update for commands, current for ticks
  assign q_entry.is_cmd = in_data.cmd;
  assign q_entry.idx    = phase_r;
  assign q_entry.hv     = hv_nxt;
  assign q_entry.laser  = laser_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r    <= 1'b0;
      laser_r <= 1'b0;
      phase_r <= '0;
    end else begin
      hv_r    <= hv_nxt;
      laser_r <= laser_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

[src/qsdg_fifo.sv]
// ----------------------------------------------------------------------------
// qsdg_fifo
// Short queue of classified words between front and back.
// ----------------------------------------------------------------------------
module qsdg_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  qsdg_pkg::entry_t   wr_entry,
  input  logic               pop,
  output qsdg_pkg::entry_t   rd_entry,
  output qsdg_pkg::q_stat_t  stat
);

  localparam int PTR_W = $clog2(qsdg_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(qsdg_pkg::QUEUE_DEPTH + 1);

  qsdg_pkg::entry_t mem_r [qsdg_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_pop;

  assign stat.full  = (count_r == CNT_W'(qsdg_pkg::QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign rd_entry   = mem_r[rd_ptr_r];
  assign do_pop     = pop && !stat.empty;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(qsdg_pkg::QUEUE_DEPTH - 1)) return '0;
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push)   wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (do_pop) rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !do_pop)      count_r <= count_r + 1'b1;
      else if (!push && do_pop) count_r <= count_r - 1'b1;
    end
  end

endmodule

[src/qsdg_back.sv]
// ----------------------------------------------------------------------------
// qsdg_back
// Sine lookup, amplitude scaling and DAC word sequencing with output register.
// ----------------------------------------------------------------------------
module qsdg_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  qsdg_pkg::q_stat_t  q_stat,
  input  qsdg_pkg::entry_t   q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output qsdg_pkg::out_t     out_data
);

  localparam int IW = qsdg_pkg::IDX_W;
  localparam int CW = qsdg_pkg::CNT_W;
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] MAG_DIV     = 64'd10 * Q30_ONE;

  typedef logic signed [15:0] sine_tab_t [qsdg_pkg::TABLE_DEPTH];

  // 0.9*sin in Q1.15, Taylor series in Q30, evaluated at elaboration
  function automatic logic signed [15:0] sine_entry(input int unsigned i);
    logic [63:0] f, r, x, x2, t, s, mag;
    f = (64'(i) << 32) / qsdg_pkg::TABLE_DEPTH;
    r = f & (Q30_ONE - 64'd1);
    if (f[30]) r = Q30_ONE - r;
    x  = (r * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) >> 30) / 156;
    t  = Q30_ONE - ((x2 * t) >> 30) / 110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    mag = (s * 64'd294912 + 64'd5 * Q30_ONE) / MAG_DIV;
    if (f[31]) return -16'(mag);
    return 16'(mag);
  endfunction

  function automatic sine_tab_t build_sine_rom();
    sine_tab_t tab;
    for (int i = 0; i < qsdg_pkg::TABLE_DEPTH; i++) begin
      tab[i] = sine_entry(i);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_ROM = build_sine_rom();

  logic [15:0] amp_x_r, amp_y_r;

  // stage A: ROM read, stage B: scaled offsets, stage C: word sequencer
  logic                    a_v_r, b_v_r, c_v_r, o_v_r;
  qsdg_pkg::entry_t        a_info_r, b_info_r, c_info_r;
  logic signed [15:0]      rom_x_r, rom_y_r;
  logic [15:0]             mx_r, my_r;
  logic                    neg_x_r, neg_y_r;
  logic [15:0]             val_a_r, val_b_r, val_c_r, val_d_r;
  logic [CW-1:0]           c_cnt_r;
  qsdg_pkg::out_t          o_data_r, word_nxt;

  logic                    a_ready, b_ready, c_ready, o_free, c_last;
  logic [IW:0]             idy_sum;
  logic [IW-1:0]           idy;
  logic [15:0]             mag_x, mag_y;
  logic [31:0]             prod_x, prod_y;
  logic [15:0]             px, nx, py, ny;

  assign cfg_ready = 1'b1;

  assign o_free  = !o_v_r || !out_stall;
  assign c_last  = c_info_r.is_cmd || (c_cnt_r == CW'(qsdg_pkg::WORDS_PER_TICK - 1));
  assign c_ready = !c_v_r || (o_free && c_last);
  assign b_ready = !b_v_r || c_ready;
  assign a_ready = !a_v_r || b_ready;
  assign q_pop   = a_ready && !q_stat.empty;

  // quarter-table offset for the Y channel, wrapped at the depth
  assign idy_sum = {1'b0, q_head.idx} + (IW + 1)'(qsdg_pkg::QUARTER);
  assign idy     = (idy_sum >= (IW + 1)'(qsdg_pkg::TABLE_DEPTH))
                 ? IW'(idy_sum - (IW + 1)'(qsdg_pkg::TABLE_DEPTH))
                 : IW'(idy_sum);

  // sign-magnitude product, truncates toward zero
  assign mag_x  = rom_x_r[15] ? 16'(-rom_x_r) : 16'(rom_x_r);
  assign mag_y  = rom_y_r[15] ? 16'(-rom_y_r) : 16'(rom_y_r);
  assign prod_x = 32'(amp_x_r) * 32'(mag_x);
  assign prod_y = 32'(amp_y_r) * 32'(mag_y);

  assign px = qsdg_pkg::MID_CODE + mx_r;
  assign nx = qsdg_pkg::MID_CODE - mx_r;
  assign py = qsdg_pkg::MID_CODE + my_r;
  assign ny = qsdg_pkg::MID_CODE - my_r;

  always_comb begin
    word_nxt.hv_enable = c_info_r.hv;
    word_nxt.laser_on  = c_info_r.laser;
    word_nxt.last      = c_last;
    if (c_info_r.is_cmd) begin
      word_nxt.dac_word   = '0;
      word_nxt.word_valid = 1'b0;
    end else begin
      word_nxt.word_valid = 1'b1;
      case (c_cnt_r)
        CW'(0):  word_nxt.dac_word = {qsdg_pkg::DAC_CMD_A, val_a_r};
        CW'(1):  word_nxt.dac_word = {qsdg_pkg::DAC_CMD_B, val_b_r};
        CW'(2):  word_nxt.dac_word = {qsdg_pkg::DAC_CMD_C, val_c_r};
        default: word_nxt.dac_word = {qsdg_pkg::DAC_CMD_D, val_d_r};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_x_r <= qsdg_pkg::AMP_RESET;
      amp_y_r <= qsdg_pkg::AMP_RESET;
      a_v_r   <= 1'b0;
      b_v_r   <= 1'b0;
      c_v_r   <= 1'b0;
      o_v_r   <= 1'b0;
      c_cnt_r <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          qsdg_pkg::CFG_AMP_X: amp_x_r <= cfg_data;
          qsdg_pkg::CFG_AMP_Y: amp_y_r <= cfg_data;
          default:             ;
        endcase
      end
      if (a_ready) a_v_r <= !q_stat.empty;
      if (b_ready) b_v_r <= a_v_r;
      if (c_ready) c_v_r <= b_v_r;
      if (o_free)  o_v_r <= c_v_r;
      if (c_ready)                c_cnt_r <= '0;
      else if (c_v_r && o_free)   c_cnt_r <= c_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready) begin
      a_info_r <= q_head;
      rom_x_r  <= SINE_ROM[q_head.idx];
      rom_y_r  <= SINE_ROM[idy];
    end
    if (b_ready) begin
      b_info_r <= a_info_r;
      mx_r     <= prod_x[31:16];
      my_r     <= prod_y[31:16];
      neg_x_r  <= rom_x_r[15];
      neg_y_r  <= rom_y_r[15];
    end
    if (c_ready) begin
      c_info_r <= b_info_r;
      val_a_r  <= neg_x_r ? nx : px;
      val_b_r  <= neg_x_r ? px : nx;
      val_c_r  <= neg_y_r ? ny : py;
      val_d_r  <= neg_y_r ? py : ny;
    end
    if (o_free) begin
      o_data_r <= word_nxt;
    end
  end

  assign out_valid = o_v_r;
  assign out_data  = o_data_r;

endmodule

[src/quadrature_sine_dac_word_generator_unit.sv]
// ----------------------------------------------------------------------------
// quadrature_sine_dac_word_generator_unit
// Sine table quadrature generator emitting four DAC words per sample tick.
// ----------------------------------------------------------------------------
// Path: the first word of an input passes the queue, stages A, B and C and
// the output register. Throughput while out_stall is low: a tick as four words
// through the output register, one per cycle; a command byte every cycle.
// Reset: synchronous, active low; flags and phase index clear, both
// amplitudes return to 10813, queue and pipeline empty. The sine ROM is fixed.
// ----------------------------------------------------------------------------
//
// Structure:
//   front  - takes input words, decodes command bytes ('1','h','d' set the
//            high-voltage enable, '0' clears it, 'l' toggles the laser),
//            stamps each word with the flags and the phase index, and
//            advances the index on ticks.
//   fifo   - two-entry queue; front stalls only when it is full.
//   back   - ROM read at index and index plus a quarter table (registered),
//            then amp*|s|>>16 with sign restored, then a four-word sequencer
//            feeding the output register. A command byte yields one status
//            word with word_valid low and last high.
// Each back stage advances when it is empty or the next stage takes its word,
// so the next tick is looked up and scaled while the current one emits words.
//
module quadrature_sine_dac_word_generator_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  qsdg_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output qsdg_pkg::out_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [15:0]     cfg_data
);

  logic               q_push, q_pop;
  qsdg_pkg::entry_t   q_wr, q_head;
  qsdg_pkg::q_stat_t  q_stat;

  qsdg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_entry  (q_wr),
    .q_stat   (q_stat)
  );

  qsdg_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (q_wr),
    .pop      (q_pop),
    .rd_entry (q_head),
    .stat     (q_stat)
  );

  qsdg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[src/qsdg_checker.sv]
// ----------------------------------------------------------------------------
// qsdg_checker
// Port-level checks on the word generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "quadrature_sine_dac_word_generator_unit_assert.svh"

module qsdg_checker (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            out_valid,
  input  logic            out_stall,
  input  qsdg_pkg::out_t  out_data,
  input  logic            cfg_valid,
  input  logic            cfg_ready
);

  logic chan_word, is_last_chan, chan_byte_ok, out_wait;

  assign chan_word    = out_valid && out_data.word_valid;
  assign is_last_chan = (out_data.dac_word[23:16] == qsdg_pkg::DAC_CMD_D);
  assign chan_byte_ok = (out_data.dac_word[23:16] == qsdg_pkg::DAC_CMD_A) ||
                        (out_data.dac_word[23:16] == qsdg_pkg::DAC_CMD_B) ||
                        (out_data.dac_word[23:16] == qsdg_pkg::DAC_CMD_C) ||
                        is_last_chan;
  assign out_wait     = out_valid && out_stall;

  // stalled word holds
  `QSDG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_wait, out_valid && $stable(out_data))

  // channel words carry one of the four DAC command bytes
  `QSDG_ASSERT_NOW(a_chan_byte, clk, rst_n, chan_word, chan_byte_ok)

  // last marks exactly the fourth channel word of a tick
  `QSDG_ASSERT_NOW(a_chan_last, clk, rst_n, chan_word, out_data.last == is_last_chan)

  // status words are empty and always last
  `QSDG_ASSERT_NOW(a_status, clk, rst_n, out_valid && !out_data.word_valid, out_data.last && (out_data.dac_word == 24'd0))

  // configuration port never back-pressures
  `QSDG_ASSERT_NOW(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready)

endmodule

bind quadrature_sine_dac_word_generator_unit qsdg_checker u_qsdg_checker (.*);

[bench/tb_quadrature_sine_dac_word_generator_unit.sv]
// ----------------------------------------------------------------------------
// tb_quadrature_sine_dac_word_generator_unit
// Self-checking bench for the quadrature sine DAC word generator.
// A table of probe words runs first, checked against typed-in status words
// where they are obvious and against a bit-true model of the sine table,
// scaling and flag logic otherwise. Random ticks and command bytes follow,
// under several amplitude settings and three idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_quadrature_sine_dac_word_generator_unit;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 24;
  localparam int PLAN_ROWS    = 22;
  localparam int RANDOM_RUN   = 40;

  // kinds of input word
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_CMD  = 1'b1;

  // register indexes with no register behind them
  localparam logic [1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [1:0] CFG_SPARE_HI = 2'd3;

  // fixed-point constants of the table evaluation
  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // one probe row: input word, and the status word when it is typed in
  typedef struct packed {
    logic       cmd;
    logic [7:0] cbyte;
    logic       typed;
    logic       hv;
    logic       laser;
  } probe_row_t;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_stall;
  qsdg_pkg::in_t   in_data;
  logic            out_valid;
  logic            out_stall;
  qsdg_pkg::out_t  out_data;
  logic            cfg_valid;
  logic            cfg_ready;
  logic  [1:0]     cfg_index;
  logic  [15:0]    cfg_data;

  // bench copy of the block's state
  logic signed [15:0] sine_tab [qsdg_pkg::TABLE_DEPTH];
  logic [15:0]        amp_x_now;
  logic [15:0]        amp_y_now;
  int unsigned        phase_now;
  logic               hv_now;
  logic               laser_now;

  qsdg_pkg::out_t expected_words [$];
  qsdg_pkg::out_t head_word;
  int   mismatch_count;
  int   cycle_count;
  int   send_gap_pct;
  int   stall_pct;

  probe_row_t probe_plan [PLAN_ROWS] = '{
    '{KIND_TICK, 8'h00,                 1'b0, 1'b0, 1'b0},
    '{KIND_TICK, 8'hFF,                 1'b0, 1'b0, 1'b0},
    '{KIND_CMD,  qsdg_pkg::CMD_HV_ON,   1'b1, 1'b1, 1'b0},
    '{KIND_TICK, 8'h5A,                 1'b0, 1'b0, 1'b0},
    '{KIND_CMD,  qsdg_pkg::CMD_HV_OFF,  1'b1, 1'b0, 1'b0},
    '{KIND_CMD,  qsdg_pkg::CMD_LASER,   1'b1, 1'b0, 1'b1},
    '{KIND_CMD,  qsdg_pkg::CMD_HV_HIGH, 1'b1, 1'b1, 1'b1},
    '{KIND_TICK, 8'hA5,                 1'b0, 1'b0, 1'b0},
    '{KIND_CMD,  qsdg_pkg::CMD_LASER,   1'b1, 1'b1, 1'b0},
    '{KIND_CMD,  qsdg_pkg::CMD_HV_OFF,  1'b1, 1'b0, 1'b0},
    '{KIND_CMD,  qsdg_pkg::CMD_HV_DAC,  1'b1, 1'b1, 1'b0},
    '{KIND_CMD,  8'h00,                 1'b1, 1'b1, 1'b0},
    '{KIND_CMD,  8'hFF,                 1'b1, 1'b1, 1'b0},
    '{KIND_CMD,  "L",                   1'b1, 1'b1, 1'b0},
    '{KIND_CMD,  "H",                   1'b1, 1'b1, 1'b0},
    '{KIND_CMD,  qsdg_pkg::CMD_HV_OFF,  1'b1, 1'b0, 1'b0},
    '{KIND_CMD,  "D",                   1'b1, 1'b0, 1'b0},
    '{KIND_TICK, 8'h00,                 1'b0, 1'b0, 1'b0},
    '{KIND_CMD,  qsdg_pkg::CMD_LASER,   1'b1, 1'b0, 1'b1},
    '{KIND_TICK, qsdg_pkg::CMD_HV_ON,   1'b0, 1'b0, 1'b0},  // byte on a tick is ignored
    '{KIND_CMD,  "2",                   1'b1, 1'b0, 1'b1},
    '{KIND_CMD,  qsdg_pkg::CMD_LASER,   1'b1, 1'b0, 1'b0}
  };

  quadrature_sine_dac_word_generator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Table entry: Q32 angle, folded into the first quadrant, Taylor series
  // in Q30 with every nested step truncated, then scaled by 0.9 and
  // rounded half up. The lower half of the circle is negated.
  function automatic logic signed [15:0] sine_value(int unsigned i);
    longint unsigned divs [6] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
    longint unsigned wide_i;
    longint unsigned f, r, x, x2, t, s, mag;
    logic [1:0] quad;
    wide_i = i;
    f = (wide_i << 32) / 64'(qsdg_pkg::TABLE_DEPTH);
    quad = f[31:30];
    r = f & (Q30_ONE - 64'd1);
    if (quad[0]) r = Q30_ONE - r;
    x = (r * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    t = Q30_ONE;
    for (int k = 0; k < 6; k++) t = Q30_ONE - ((x2 * t) >> 30) / divs[k];
    s = (x * t) >> 30;
    mag = (s * 64'd294912 + 64'd5 * Q30_ONE) / (64'd10 * Q30_ONE);
    return quad[1] ? -mag[15:0] : mag[15:0];
  endfunction

  // amp * |s| >> 16, truncated toward zero, sign put back
  function automatic int scaled_offset(logic [15:0] amp, logic signed [15:0] s);
    int mag;
    int m;
    mag = (s < 0) ? -int'(s) : int'(s);
    m = (int'({16'd0, amp}) * mag) >>> 16;
    return (s < 0) ? -m : m;
  endfunction

  // Works out the words one accepted input causes and queues them.
  task automatic queue_dac_frames(qsdg_pkg::in_t w);
    int unsigned ix, iy;
    int tx, ty;
    logic [7:0]  chan_cmd [4];
    logic [15:0] chan_val [4];
    qsdg_pkg::out_t o;
    if (w.cmd == KIND_CMD) begin
      case (w.command_byte)
        qsdg_pkg::CMD_HV_ON, qsdg_pkg::CMD_HV_HIGH, qsdg_pkg::CMD_HV_DAC: hv_now = 1'b1;
        qsdg_pkg::CMD_HV_OFF: hv_now = 1'b0;
        qsdg_pkg::CMD_LASER:  laser_now = ~laser_now;
        default: ;
      endcase
      o = '{dac_word: 24'd0, word_valid: 1'b0, last: 1'b1,
            hv_enable: hv_now, laser_on: laser_now};
      expected_words.push_back(o);
    end else begin
      ix = phase_now;
      iy = (ix + qsdg_pkg::QUARTER) % qsdg_pkg::TABLE_DEPTH;
      tx = scaled_offset(amp_x_now, sine_tab[ix]);
      ty = scaled_offset(amp_y_now, sine_tab[iy]);
      chan_cmd = '{qsdg_pkg::DAC_CMD_A, qsdg_pkg::DAC_CMD_B,
                   qsdg_pkg::DAC_CMD_C, qsdg_pkg::DAC_CMD_D};
      chan_val = '{qsdg_pkg::MID_CODE + 16'(tx), qsdg_pkg::MID_CODE - 16'(tx),
                   qsdg_pkg::MID_CODE + 16'(ty), qsdg_pkg::MID_CODE - 16'(ty)};
      for (int k = 0; k < qsdg_pkg::WORDS_PER_TICK; k++) begin
        o = '{dac_word: {chan_cmd[k], chan_val[k]}, word_valid: 1'b1,
              last: (k == qsdg_pkg::WORDS_PER_TICK - 1), hv_enable: hv_now,
              laser_on: laser_now};
        expected_words.push_back(o);
      end
      phase_now = (ix + 1) % qsdg_pkg::TABLE_DEPTH;
    end
  endtask

  // Offers one word; valid stays high afterwards so that the next word can
  // follow at once without a low/high pair in one step.
  task automatic send_word(qsdg_pkg::in_t w);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    queue_dac_frames(w);
  endtask

  function automatic qsdg_pkg::in_t random_word();
    logic [7:0] decoded [5] = '{qsdg_pkg::CMD_HV_ON, qsdg_pkg::CMD_HV_OFF,
                                qsdg_pkg::CMD_LASER, qsdg_pkg::CMD_HV_HIGH,
                                qsdg_pkg::CMD_HV_DAC};
    qsdg_pkg::in_t w;
    int pick;
    pick = $urandom_range(99);
    w.cmd = KIND_TICK;
    w.command_byte = 8'($urandom);
    if (pick >= 55) begin
      w.cmd = KIND_CMD;
      if (pick < 85) w.command_byte = decoded[$urandom_range(4)];
    end
    return w;
  endfunction

  task automatic run_random(int count);
    for (int n = 0; n < count; n++) send_word(random_word());
  endtask

  // Waits for the block to drain, then writes a spare index, amp_x and
  // amp_y back to back with valid held high.
  task automatic write_amplitudes(logic [15:0] x, logic [15:0] y);
    logic [1:0] spare;
    spare = $urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO;
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    for (int k = 0; k < 3; k++) begin
      case (k)
        0: begin cfg_index <= spare;               cfg_data <= 16'($urandom); end
        1: begin cfg_index <= qsdg_pkg::CFG_AMP_X; cfg_data <= x; end
        default: begin cfg_index <= qsdg_pkg::CFG_AMP_Y; cfg_data <= y; end
      endcase
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    amp_x_now = x;
    amp_y_now = y;
  endtask

  task automatic report_mismatch(string what, qsdg_pkg::out_t want, qsdg_pkg::out_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t %s: want %06h v%0b l%0b hv%0b la%0b, got %06h v%0b l%0b hv%0b la%0b",
               $realtime, what, want.dac_word, want.word_valid, want.last,
               want.hv_enable, want.laser_on, got.dac_word, got.word_valid,
               got.last, got.hv_enable, got.laser_on);
  endtask

  // receiver: random stall at the rate of the current phase
  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // result checker, field by field against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", '0, out_data);
      end else begin
        head_word = expected_words.pop_front();
        if (out_data.dac_word   !== head_word.dac_word   ||
            out_data.word_valid !== head_word.word_valid ||
            out_data.last       !== head_word.last       ||
            out_data.hv_enable  !== head_word.hv_enable  ||
            out_data.laser_on   !== head_word.laser_on)
          report_mismatch("word mismatch", head_word, out_data);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** quadrature_sine_dac_word_generator_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    qsdg_pkg::in_t w;
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = qsdg_pkg::CFG_AMP_X;
    cfg_data = '0;
    mismatch_count = 0;
    cycle_count = 0;
    send_gap_pct = 6;
    stall_pct = 76;
    amp_x_now = qsdg_pkg::AMP_RESET;
    amp_y_now = qsdg_pkg::AMP_RESET;
    phase_now = 0;
    hv_now = 1'b0;
    laser_now = 1'b0;
    for (int i = 0; i < qsdg_pkg::TABLE_DEPTH; i++) sine_tab[i] = sine_value(i);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Probe table at reset amplitudes. Status words of command bytes are
    // typed in and replace the model's guess; ticks go to the model.
    for (int r = 0; r < PLAN_ROWS; r++) begin
      w.cmd = probe_plan[r].cmd;
      w.command_byte = probe_plan[r].cbyte;
      send_word(w);
      if (probe_plan[r].typed) begin
        void'(expected_words.pop_back());
        expected_words.push_back('{dac_word: 24'd0, word_valid: 1'b0, last: 1'b1,
                                   hv_enable: probe_plan[r].hv,
                                   laser_on: probe_plan[r].laser});
      end
    end

    // sender mostly busy, receiver mostly stalled
    write_amplitudes(16'd0, 16'd32768);
    run_random(RANDOM_RUN);
    write_amplitudes(16'd32768, 16'd0);
    run_random(RANDOM_RUN);

    // the other way round
    send_gap_pct = 76;
    stall_pct = 6;
    write_amplitudes(16'($urandom_range(32768)), 16'($urandom_range(32768)));
    run_random(RANDOM_RUN);
    write_amplitudes(16'd65535, 16'd65535);
    run_random(RANDOM_RUN);

    // no idling on either side
    send_gap_pct = 0;
    stall_pct = 0;
    write_amplitudes(16'($urandom), 16'($urandom));
    run_random(RANDOM_RUN);
    write_amplitudes(16'd32768, 16'd32768);
    run_random(RANDOM_RUN);

    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_words.size() == 0)
      $display("** quadrature_sine_dac_word_generator_unit: PASSED **");
    else
      $display("** quadrature_sine_dac_word_generator_unit: FAILED **");
    $finish;
  end

endmodule
